>>> sv/wmv_pkg.sv
package wmv_pkg;

  localparam int unsigned DEPTH   = 4;
  localparam int unsigned AXES    = 3;
  localparam int unsigned COORD_W = 16;

  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SLOT_W = $clog2(DEPTH);
  localparam int unsigned AXIS_W = $clog2(AXES + 1);

  // Window sum, magnitudes and sum of squares
  localparam int unsigned SUM_W = COORD_W + $clog2(DEPTH) + 1;
  localparam int unsigned MAG_W = COORD_W + 1;
  localparam int unsigned SMG_W = SUM_W;
  localparam int unsigned SQ_W  = 2 * (COORD_W - 1) + $clog2(DEPTH) + 1;
  localparam int unsigned MSQ_W = 2 * (COORD_W - 1) + 2;

  localparam int unsigned VAR_W  = 31;
  localparam int unsigned NORM_W = 64;

  // Shared multiplier
  localparam int unsigned MUL_W  = 32;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // floor(x / 3) = (x * RECIP3) >> RECIP3_SHIFT for any x below 2^32
  localparam logic [MUL_W-1:0] RECIP3       = 32'hAAAA_AAAB;
  localparam int unsigned      RECIP3_SHIFT = 33;

  localparam logic [VAR_W-1:0] LIMIT_RESET = VAR_W'(268435);

endpackage

>>> sv/window_mean_variance_3axis.sv
// Channel   Direction  Handshake                   Payload
// in        sink       in_valid_i / in_ready_o     pos_x_i, pos_y_i, pos_z_i
// out       source     out_valid_o / out_ready_i   mean_*_o, var_*_o, stable_o, fill_count_o
// cfg       sink       cfg_valid_i / cfg_ready_o   stable_limit_i
//
// Every square, reciprocal division and norm term goes through the one shared
// 32 x 32 multiplier, so the steps of an item run one after another; the fill
// count n, the number of samples in the window, runs from 1 to 4.
// rst_ni clears the window count, write slot and output valid, and loads the limit
// with its reset value. The input side is not ready while an item is in work; a
// result waiting on out_ready_i holds only the final copy step, so the next item
// may be accepted once that result has been moved into the output register.
module window_mean_variance_3axis
  import wmv_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,

  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] pos_x_i,
  input  logic signed [COORD_W-1:0] pos_y_i,
  input  logic signed [COORD_W-1:0] pos_z_i,

  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [COORD_W-1:0] mean_x_o,
  output logic signed [COORD_W-1:0] mean_y_o,
  output logic signed [COORD_W-1:0] mean_z_o,
  output logic        [VAR_W-1:0]   var_x_o,
  output logic        [VAR_W-1:0]   var_y_o,
  output logic        [VAR_W-1:0]   var_z_o,
  output logic                      stable_o,
  output logic        [CNT_W-1:0]   fill_count_o,

  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic        [VAR_W-1:0]   stable_limit_i
);

  typedef enum logic [2:0] {
    S_IDLE,   // wait for an item, store it in the window
    S_ACC,    // walk the window: sum samples, square and sum magnitudes
    S_DIVSQ,  // start sum of squares / 3
    S_DIVM,   // settle mean of squares, start |sum| / 3
    S_MSQ,    // settle mean, square it
    S_VAR,    // variance for this axis
    S_NORM,   // square and add the variances, then square the limit
    S_CMP     // compare and hand over to the output register
  } state_e;

  state_e state_q;

  // Window store and fill bookkeeping
  logic signed [COORD_W-1:0] win_q [DEPTH][AXES];
  logic [CNT_W-1:0]          held_q;
  logic [SLOT_W-1:0]         slot_q;
  logic [VAR_W-1:0]          limit_q;

  // Working registers
  logic [CNT_W-1:0]          idx_q;
  logic [AXIS_W-1:0]         axis_q;
  logic [AXIS_W-1:0]         nidx_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic [SQ_W-1:0]           sumsq_q;
  logic [MSQ_W-1:0]          msq_q;
  logic                      pv_q;
  logic [PROD_W-1:0]         prod_q;
  logic [NORM_W-1:0]         norm_q;
  logic signed [COORD_W-1:0] mean_q [AXES];
  logic [VAR_W-1:0]          var_q  [AXES];

  // Output register
  logic                      out_valid_q;
  logic signed [COORD_W-1:0] out_mean_q [AXES];
  logic [VAR_W-1:0]          out_var_q  [AXES];
  logic                      out_stable_q;
  logic [CNT_W-1:0]          out_fill_q;

  // Combinational helpers
  logic signed [COORD_W-1:0] sample;
  logic [MAG_W-1:0]          sample_mag;
  logic [SMG_W-1:0]          sum_mag;
  logic [1:0]                div_sh;
  logic                      div3;
  logic [MAG_W-1:0]          mean_mag;
  logic [MAG_W-1:0]          mean_signed;
  logic [MSQ_W-1:0]          mean_sq;
  logic [MSQ_W-1:0]          var_diff;
  logic [VAR_W-1:0]          var_d;
  logic [MUL_W-1:0]          mul_a;
  logic [MUL_W-1:0]          mul_b;
  logic [PROD_W-1:0]         prod_d;
  logic                      out_load;

  assign sample     = win_q[idx_q[SLOT_W-1:0]][axis_q];
  assign sample_mag = sample[COORD_W-1] ? MAG_W'(-$signed({sample[COORD_W-1], sample}))
                                        : MAG_W'({sample[COORD_W-1], sample});
  assign sum_mag    = sum_q[SUM_W-1] ? SMG_W'(-sum_q) : SMG_W'(sum_q);

  // Divide by the fill count: a shift for one, two and four, the reciprocal for three
  assign div3 = (held_q == CNT_W'(3));
  always_comb begin
    case (held_q)
      CNT_W'(1): div_sh = 2'd0;
      CNT_W'(2): div_sh = 2'd1;
      default:   div_sh = 2'd2;
    endcase
  end

  assign mean_mag    = div3 ? prod_q[RECIP3_SHIFT +: MAG_W] : MAG_W'(sum_mag >> div_sh);
  assign mean_signed = sum_q[SUM_W-1] ? MAG_W'(-mean_mag) : mean_mag;
  assign mean_sq     = prod_q[MSQ_W-1:0];
  assign var_diff    = msq_q - mean_sq;

  // Clamp below at zero, saturate above
  always_comb begin
    if (msq_q <= mean_sq) begin
      var_d = '0;
    end else if (var_diff[MSQ_W-1]) begin
      var_d = '1;
    end else begin
      var_d = var_diff[VAR_W-1:0];
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    case (state_q)
      S_ACC: begin
        mul_a = MUL_W'(sample_mag);
        mul_b = MUL_W'(sample_mag);
      end
      S_DIVSQ: begin
        mul_a = sumsq_q[MUL_W-1:0];
        mul_b = RECIP3;
      end
      S_DIVM: begin
        mul_a = MUL_W'(sum_mag);
        mul_b = RECIP3;
      end
      S_MSQ: begin
        mul_a = MUL_W'(mean_mag);
        mul_b = MUL_W'(mean_mag);
      end
      S_NORM: begin
        if (nidx_q == AXIS_W'(AXES)) begin
          mul_a = MUL_W'(limit_q);
          mul_b = MUL_W'(limit_q);
        end else begin
          mul_a = MUL_W'(var_q[nidx_q]);
          mul_b = MUL_W'(var_q[nidx_q]);
        end
      end
      S_CMP: begin
        // Keep the limit squared in the product register while the result waits
        mul_a = MUL_W'(limit_q);
        mul_b = MUL_W'(limit_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Final copy step: the output register is free or is emptied in this cycle
  assign out_load = (state_q == S_CMP) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      slot_q      <= '0;
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
      pv_q        <= 1'b0;
    end else begin
      prod_q <= prod_d;

      if (cfg_valid_i) begin
        limit_q <= stable_limit_i;
      end

      // Load a new result, or drop the old one once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            win_q[slot_q][0] <= pos_x_i;
            win_q[slot_q][1] <= pos_y_i;
            win_q[slot_q][2] <= pos_z_i;
            slot_q  <= (slot_q == SLOT_W'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
            if (held_q != CNT_W'(DEPTH)) begin
              held_q <= held_q + 1'b1;
            end
            idx_q   <= '0;
            axis_q  <= '0;
            sum_q   <= '0;
            sumsq_q <= '0;
            pv_q    <= 1'b0;
            state_q <= S_ACC;
          end
        end

        S_ACC: begin
          // Add the square issued last cycle while the next one is formed
          if (pv_q) begin
            sumsq_q <= sumsq_q + prod_q[SQ_W-1:0];
          end
          if (idx_q != held_q) begin
            sum_q <= sum_q + SUM_W'(sample);
            pv_q  <= 1'b1;
            idx_q <= idx_q + 1'b1;
          end else begin
            pv_q    <= 1'b0;
            state_q <= S_DIVSQ;
          end
        end

        S_DIVSQ: begin
          state_q <= S_DIVM;
        end

        S_DIVM: begin
          msq_q   <= div3 ? MSQ_W'(prod_q[PROD_W-1:RECIP3_SHIFT]) : MSQ_W'(sumsq_q >> div_sh);
          state_q <= S_MSQ;
        end

        S_MSQ: begin
          mean_q[axis_q] <= mean_signed[COORD_W-1:0];
          state_q        <= S_VAR;
        end

        S_VAR: begin
          var_q[axis_q] <= var_d;
          if (axis_q == AXIS_W'(AXES - 1)) begin
            nidx_q  <= '0;
            norm_q  <= '0;
            pv_q    <= 1'b0;
            state_q <= S_NORM;
          end else begin
            axis_q  <= axis_q + 1'b1;
            idx_q   <= '0;
            sum_q   <= '0;
            sumsq_q <= '0;
            pv_q    <= 1'b0;
            state_q <= S_ACC;
          end
        end

        S_NORM: begin
          if (pv_q) begin
            norm_q <= norm_q + prod_q;
          end
          if (nidx_q != AXIS_W'(AXES)) begin
            pv_q   <= 1'b1;
            nidx_q <= nidx_q + 1'b1;
          end else begin
            // Limit squared is issued in this cycle
            pv_q    <= 1'b0;
            state_q <= S_CMP;
          end
        end

        S_CMP: begin
          // Hold here while the previous result is still waiting
          if (out_load) begin
            for (int a = 0; a < AXES; a++) begin
              out_mean_q[a] <= mean_q[a];
              out_var_q[a]  <= var_q[a];
            end
            out_stable_q <= (norm_q <= prod_q);
            out_fill_q   <= held_q;
            state_q      <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mean_x_o     = out_mean_q[0];
  assign mean_y_o     = out_mean_q[1];
  assign mean_z_o     = out_mean_q[2];
  assign var_x_o      = out_var_q[0];
  assign var_y_o      = out_var_q[1];
  assign var_z_o      = out_var_q[2];
  assign stable_o     = out_stable_q;
  assign fill_count_o = out_fill_q;

  // The window count never runs past the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) held_q <= CNT_W'(DEPTH))
    else $error("window count beyond depth");

  // A result always covers at least one and at most DEPTH samples
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fill_count_o != '0) && (fill_count_o <= CNT_W'(DEPTH)))
    else $error("fill count out of range");

  // An accepted item keeps the input side busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while an item is in work");

  // A new result is never loaded over one that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(var_x_o) && $stable(mean_x_o))
    else $error("waiting result overwritten");

endmodule

>>> dv/window_mean_variance_3axis_test.sv
`timescale 1ns / 1ps

module window_mean_variance_3axis_test;
  import wmv_pkg::*;

  // Largest variance the result port can carry; wider values saturate
  localparam longint VAR_CEIL = (longint'(1) << VAR_W) - 1;

  // Three coordinates of one position item, x in slot 0
  typedef logic [AXES-1:0][COORD_W-1:0] position_t;

  // Statistics of one result item, axis order as above
  typedef struct packed {
    logic [AXES-1:0][COORD_W-1:0] mean;
    logic [AXES-1:0][VAR_W-1:0]   variance;
    logic                         stable;
    logic [CNT_W-1:0]             fill;
  } window_stats_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;

  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic signed [COORD_W-1:0] pos_x_i = '0;
  logic signed [COORD_W-1:0] pos_y_i = '0;
  logic signed [COORD_W-1:0] pos_z_i = '0;

  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [COORD_W-1:0] mean_x_o;
  logic signed [COORD_W-1:0] mean_y_o;
  logic signed [COORD_W-1:0] mean_z_o;
  logic        [VAR_W-1:0]   var_x_o;
  logic        [VAR_W-1:0]   var_y_o;
  logic        [VAR_W-1:0]   var_z_o;
  logic                      stable_o;
  logic        [CNT_W-1:0]   fill_count_o;

  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic        [VAR_W-1:0]   stable_limit_i = LIMIT_RESET;

  window_mean_variance_3axis u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .mean_x_o      (mean_x_o),
    .mean_y_o      (mean_y_o),
    .mean_z_o      (mean_z_o),
    .var_x_o       (var_x_o),
    .var_y_o       (var_y_o),
    .var_z_o       (var_z_o),
    .stable_o      (stable_o),
    .fill_count_o  (fill_count_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .stable_limit_i(stable_limit_i)
  );

  // Positions waiting to be sent, and statistics still owed by the block
  position_t     position_q[$];
  window_stats_t expected_stats_q[$];

  // Shadow of the block's window: stored samples, fill level, next slot, limit
  logic [COORD_W-1:0] win_store [DEPTH][AXES];
  int                 held = 0;
  int                 wr_slot = 0;
  logic [VAR_W-1:0]   limit_model = LIMIT_RESET;

  int  mismatch_cnt = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  bit  no_gaps = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run: about 500 items, each with its
  // work plus the longest stall on either side, with ample margin
  initial begin
    #8_000_000;
    $display("window_mean_variance_3axis: mismatch");
    $finish;
  end

  // Append one position to the shadow window and work out the statistics
  // the block must return for it. Means truncate toward zero; the variance
  // is floor(mean of squares) minus the squared truncated mean, held at
  // zero from below and saturated at the port width from above.
  function automatic window_stats_t window_stats(position_t p);
    window_stats_t        r;
    longint               coord, acc, sq_acc, avg, msq, avg_sq, spread;
    longint unsigned      norm_sq, lim;
    for (int a = 0; a < AXES; a++) win_store[wr_slot][a] = p[a];
    wr_slot = (wr_slot + 1) % DEPTH;
    if (held < DEPTH) held++;
    norm_sq = 0;
    for (int a = 0; a < AXES; a++) begin
      acc = 0;
      sq_acc = 0;
      for (int i = 0; i < held; i++) begin
        coord = longint'($signed(win_store[i][a]));
        acc += coord;
        sq_acc += coord * coord;
      end
      msq = sq_acc / longint'(held);
      avg = acc / longint'(held);
      avg_sq = avg * avg;
      spread = (msq > avg_sq) ? msq - avg_sq : 0;
      if (spread > VAR_CEIL) spread = VAR_CEIL;
      r.mean[a] = avg[COORD_W-1:0];
      r.variance[a] = spread[VAR_W-1:0];
      norm_sq += longint'(spread) * longint'(spread);
    end
    // Compare the norm in squared form, so no root is taken
    lim = longint'(limit_model);
    r.stable = (norm_sq <= lim * lim);
    r.fill = CNT_W'(held);
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Append one position to the send queue
  function automatic void add_position(position_t p);
    position_q = {position_q, p};
  endfunction

  task automatic report_miss(string what, longint expv, longint gotv);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t: %s expected %0d got %0d", $realtime, what, expv, gotv);
  endtask

  // Input driver: present queued positions, hold each until it is taken,
  // and feed every accepted item through the shadow window
  always @(posedge clk_i) begin : drive_positions
    position_t     nxt;
    window_stats_t owed;
    bit            busy;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        owed = window_stats({pos_z_i, pos_y_i, pos_x_i});
        expected_stats_q = {expected_stats_q, owed};
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (position_q.size() != 0) begin
          nxt = position_q[0];
          position_q.delete(0);
          in_valid_i <= 1'b1;
          pos_x_i <= nxt[0];
          pos_y_i <= nxt[1];
          pos_z_i <= nxt[2];
          if (!no_gaps && $urandom_range(0, 3) == 0) send_gap = gap_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: stall the result side at random and check every
  // accepted result against the oldest statistics still owed
  always @(posedge clk_i) begin : watch_results
    window_stats_t want;
    window_stats_t got;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got.mean = {mean_z_o, mean_y_o, mean_x_o};
        got.variance = {var_z_o, var_y_o, var_x_o};
        got.stable = stable_o;
        got.fill = fill_count_o;
        if (expected_stats_q.size() == 0) begin
          report_miss("result with no item owed, fill", -1, fill_count_o);
        end else begin
          want = expected_stats_q[0];
          expected_stats_q.delete(0);
          for (int a = 0; a < AXES; a++) begin
            if (got.mean[a] !== want.mean[a])
              report_miss($sformatf("mean axis %0d", a),
                          $signed(want.mean[a]), $signed(got.mean[a]));
            if (got.variance[a] !== want.variance[a])
              report_miss($sformatf("variance axis %0d", a),
                          want.variance[a], got.variance[a]);
          end
          if (got.stable !== want.stable)
            report_miss("stable", want.stable, got.stable);
          if (got.fill !== want.fill)
            report_miss("fill count", want.fill, got.fill);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!no_gaps && $urandom_range(0, 4) == 0) stall_left = gap_len();
      end
    end
  end

  function automatic position_t pos3(int x, int y, int z);
    position_t p;
    p[0] = x[COORD_W-1:0];
    p[1] = y[COORD_W-1:0];
    p[2] = z[COORD_W-1:0];
    return p;
  endfunction

  // Hold until nothing is queued, nothing is on the wire and nothing is owed
  task automatic wait_drained();
    do @(negedge clk_i);
    while (position_q.size() != 0 || in_valid_i || expected_stats_q.size() != 0);
  endtask

  // Write the limit register while the block is idle
  task automatic write_limit(logic [VAR_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    stable_limit_i <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    limit_model = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Queue random positions: mostly bursts clustered around a random centre
  // with a spread from zero up to full scale, so that the variance and the
  // stable flag sweep their range; some bursts repeat one position exactly,
  // and the rest is full-range noise
  task automatic queue_positions(int count);
    int        left, burst, spread, kind, v;
    int        centre [AXES];
    position_t p;
    left = count;
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      burst = $urandom_range(4, 12);
      if (burst > left) burst = left;
      if (kind < 2) spread = -1;
      else if (kind < 3) spread = 0;
      else spread = (1 << $urandom_range(0, 15)) - 1;
      for (int a = 0; a < AXES; a++) centre[a] = int'($signed(COORD_W'($urandom)));
      for (int k = 0; k < burst; k++) begin
        for (int a = 0; a < AXES; a++) begin
          if (spread < 0) begin
            p[a] = COORD_W'($urandom);
          end else begin
            v = centre[a] + int'($urandom_range(0, 2 * spread)) - spread;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            p[a] = v[COORD_W-1:0];
          end
        end
        add_position(p);
      end
      left -= burst;
    end
  endtask

  initial begin : run_phases
    logic [VAR_W-1:0] phase_limit [6];
    phase_limit[0] = '0;
    phase_limit[1] = {VAR_W{1'b1}};
    phase_limit[2] = VAR_W'(32'h4000_0000);
    phase_limit[3] = VAR_W'($urandom_range(0, 1 << 20));
    phase_limit[4] = VAR_W'($urandom_range(1 << 20, 1 << 28));
    phase_limit[5] = LIMIT_RESET;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset limit: the window filling from one to
    // four, full-scale extremes, means of mixed signs that truncate to zero,
    // a window of identical positions for zero variance, then wrap-around
    add_position(pos3(0, 0, 0));
    add_position(pos3(32767, -32768, 1));
    add_position(pos3(-32768, 32767, -1));
    add_position(pos3(-1, 0, 2));
    add_position(pos3(32767, 32767, 32767));
    add_position(pos3(-32768, -32768, -32768));
    add_position(pos3(32767, -32768, 32767));
    add_position(pos3(-32768, 32767, -32768));
    add_position(pos3(-32768, -32768, -32768));
    add_position(pos3(-32768, -32768, -32768));
    for (int k = 0; k < 4; k++) add_position(pos3(100, -200, 300));
    add_position(pos3(101, -200, 300));
    add_position(pos3(-3, 5, -7));
    add_position(pos3(-1, 1, -1));
    add_position(pos3(0, 0, 0));
    add_position(pos3(16384, -16384, 8192));
    add_position(pos3(-16385, 16383, -8193));

    // Random part: one limit per phase, with the sender pausing halfway
    // until every owed result has come back; one phase runs with no idling
    foreach (phase_limit[ph]) begin
      wait_drained();
      write_limit(phase_limit[ph]);
      no_gaps = (ph == 2);
      queue_positions(40);
      wait_drained();
      queue_positions(40);
    end

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("window_mean_variance_3axis: match");
    end else begin
      $display("window_mean_variance_3axis: mismatch");
    end
    $finish;
  end

endmodule
